@@ rtl/aab_pkg.sv @@
// Shared types and constants for the ARGB alpha blend pipeline.
package aab_pkg;

    localparam int          CHAN_W     = 8;
    localparam int          NUM_CHAN   = 4;
    localparam int          PIX_W      = CHAN_W * NUM_CHAN;
    localparam int          PROD_W     = 2 * CHAN_W;
    localparam logic [7:0]  ALPHA_FULL = 8'hFF;
    localparam logic [7:0]  ALPHA_ZERO = 8'h00;
    localparam int          ALPHA_CH   = 3;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_BLEND = 2'd0;
    localparam mode_t MODE_DEST  = 2'd1;
    localparam mode_t MODE_SRC   = 2'd2;

    typedef logic [PROD_W-1:0] prod_t;

    // Stage 1 -> stage 2: weighted channel products
    typedef struct packed {
        mode_t                    mode;
        logic [PIX_W-1:0]         dest;
        logic [PIX_W-1:0]         src;
        prod_t [NUM_CHAN-1:0]     prod_s;
        prod_t [NUM_CHAN-1:0]     prod_d;
    } s1_data_t;

    // Stage 2 -> stage 3: per-channel sums, max 255*255 fits in 16 bits
    typedef struct packed {
        mode_t                    mode;
        logic [PIX_W-1:0]         dest;
        logic [PIX_W-1:0]         src;
        prod_t [NUM_CHAN-1:0]     sum;
    } s2_data_t;

endpackage

@@ rtl/aab_mul_stage.sv @@
// Stage 1: case decode and per-channel alpha weighting multiplies.
module aab_mul_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    output logic                    ready_up,
    input  logic [31:0]             dest_pixel,
    input  logic [31:0]             src_color,
    input  logic                    direct_set,
    output logic                    valid_out,
    input  logic                    ready_dn,
    output aab_pkg::s1_data_t       data_out
);
    import aab_pkg::*;

    logic       valid_reg;
    s1_data_t   data_reg;
    s1_data_t   data_next;
    logic [7:0] sa;
    logic [7:0] da;
    logic [7:0] inv_a;

    assign ready_up  = !valid_reg || ready_dn;
    assign valid_out = valid_reg;
    assign data_out  = data_reg;

    always_comb
    begin
        sa    = src_color[31:24];
        da    = dest_pixel[31:24];
        inv_a = ALPHA_FULL - sa;
        data_next.dest = dest_pixel;
        data_next.src  = src_color;
        if (direct_set)
        begin
            data_next.mode = MODE_SRC;
        end
        else if (sa == ALPHA_ZERO)
        begin
            data_next.mode = MODE_DEST;
        end
        else if (sa == ALPHA_FULL || da == ALPHA_ZERO)
        begin
            data_next.mode = MODE_SRC;
        end
        else
        begin
            data_next.mode = MODE_BLEND;
        end
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            // alpha channel blends a full-scale source against dest alpha
            if (c == ALPHA_CH)
            begin
                data_next.prod_s[c] = ALPHA_FULL * sa;
            end
            else
            begin
                data_next.prod_s[c] = src_color[c*CHAN_W +: CHAN_W] * sa;
            end
            data_next.prod_d[c] = dest_pixel[c*CHAN_W +: CHAN_W] * inv_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_up)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/aab_sum_stage.sv @@
// Stage 2: sum of source and destination weighted products.
module aab_sum_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    output logic                    ready_up,
    input  aab_pkg::s1_data_t       data_in,
    output logic                    valid_out,
    input  logic                    ready_dn,
    output aab_pkg::s2_data_t       data_out
);
    import aab_pkg::*;

    logic       valid_reg;
    s2_data_t   data_reg;
    s2_data_t   data_next;

    assign ready_up  = !valid_reg || ready_dn;
    assign valid_out = valid_reg;
    assign data_out  = data_reg;

    always_comb
    begin
        data_next.mode = data_in.mode;
        data_next.dest = data_in.dest;
        data_next.src  = data_in.src;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            // s*a + d*(255-a) <= 255*255, no overflow in 16 bits
            data_next.sum[c] = data_in.prod_s[c] + data_in.prod_d[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_up)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/aab_div_stage.sv @@
// Stage 3: divide by 255, clamp, select result, output register.
module aab_div_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    output logic                    ready_up,
    input  aab_pkg::s2_data_t       data_in,
    output logic                    valid_out,
    input  logic                    ready_dn,
    output logic [31:0]             pixel_out
);
    import aab_pkg::*;

    logic             valid_reg;
    logic [31:0]      pixel_reg;
    logic [31:0]      pixel_next;
    logic [31:0]      blended;
    logic [16:0]      acc  [NUM_CHAN];
    logic [8:0]       quot [NUM_CHAN];

    assign ready_up  = !valid_reg || ready_dn;
    assign valid_out = valid_reg;
    assign pixel_out = pixel_reg;

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            // exact v/255 for v <= 255*255: (v + 1 + (v >> 8)) >> 8
            acc[c]  = {1'b0, data_in.sum[c]} + 17'd1
                      + {9'd0, data_in.sum[c][15:8]};
            quot[c] = acc[c][16:8];
            blended[c*CHAN_W +: CHAN_W] = quot[c][8] ? ALPHA_FULL : quot[c][7:0];
        end
        case (data_in.mode)
            MODE_DEST:  pixel_next = data_in.dest;
            MODE_SRC:   pixel_next = data_in.src;
            MODE_BLEND: pixel_next = blended;
            default:    pixel_next = blended;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_up)
        begin
            pixel_reg <= pixel_next;
        end
    end

endmodule

@@ rtl/argb_alpha_blend_unit.sv @@
// Top level of the ARGB8888 source-over alpha blend pipeline.
//
//  channel  beat fields                              handshake
//  -------  ---------------------------------------  -------------------
//  in       dest_pixel[31:0] src_color[31:0]         in_valid / in_stall
//           direct_set
//  out      result_pixel[31:0]                       out_valid / out_stall
//
// One beat per clock in and out while out_stall is low; an accepted input beat
// reaches out_valid through the multiply, add and divide-by-255 stage registers.
// Reset clears the three stage valid bits only; payload registers are not reset.
// out_stall holds the output register; bubbles upstream still close up, and
// in_stall rises only once all three stages hold a beat.
module argb_alpha_blend_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] dest_pixel,
    input  logic [31:0] src_color,
    input  logic        direct_set,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_pixel
);
    import aab_pkg::*;

    // stage handshake between modules
    logic       s1_ready;
    logic       s1_valid;
    s1_data_t   s1_data;
    logic       s2_ready;
    logic       s2_valid;
    s2_data_t   s2_data;
    logic       s3_ready;

    assign in_stall = !s1_ready;

    // stage 1: decode blend case, weight channels by alpha
    aab_mul_stage u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (in_valid),
        .ready_up   (s1_ready),
        .dest_pixel (dest_pixel),
        .src_color  (src_color),
        .direct_set (direct_set),
        .valid_out  (s1_valid),
        .ready_dn   (s2_ready),
        .data_out   (s1_data)
    );

    // stage 2: add weighted terms
    aab_sum_stage u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (s1_valid),
        .ready_up   (s2_ready),
        .data_in    (s1_data),
        .valid_out  (s2_valid),
        .ready_dn   (s3_ready),
        .data_out   (s2_data)
    );

    // stage 3: divide by 255, pick final pixel, drive output
    aab_div_stage u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (s2_valid),
        .ready_up   (s3_ready),
        .data_in    (s2_data),
        .valid_out  (out_valid),
        .ready_dn   (!out_stall),
        .pixel_out  (result_pixel)
    );

    // input backs up only when every stage is occupied and output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid && s2_valid && out_valid && out_stall))
        else $error("input stalled with a free pipeline slot");

    // a held stage 2 beat keeps its data
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid && !s3_ready) |=> (s2_valid && $stable(s2_data)))
        else $error("stage 2 beat lost or changed while held");

    // a held stage 1 beat keeps its data
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && !s2_ready) |=> (s1_valid && $stable(s1_data)))
        else $error("stage 1 beat lost or changed while held");

    // an unstalled output never backs up the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output drains");

endmodule
